### sv/lmsu_pkg.sv
// Package: types and constants for the lattice Metropolis site update unit.
`default_nettype none
package lmsu_pkg;
  localparam int SideMax = 16;
  localparam int MaxDims = 4;
  localparam int CoordW = $clog2(SideMax);
  localparam int AddrW = CoordW * MaxDims;
  localparam int Depth = 1 << AddrW;
  localparam int MagW = 22;
  localparam int GaussW = 20;
  localparam int NluW = 24;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam int NbrCntW = $clog2(2 * MaxDims + 1);
  localparam int SumW = MagW + NbrCntW + 1;
  localparam int ProdW = SumW + 16;
  localparam int PropW = ProdW - 16 + 1;
  localparam int SqW = 2 * MagW - 16 + 1;
  localparam int QuW = 2 * SqW - 16 + 1;
  localparam int DiffW = QuW + 1;
  localparam int LhsW = DiffW + 17;
  localparam logic [MagW-1:0] MagMax = '1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIMS  = 2'd0,
    CFG_SIDE  = 2'd1,
    CFG_KAPPA = 2'd2,
    CFG_COUP  = 2'd3
  } cfg_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [CoordW-1:0] coord_a;
    logic [CoordW-1:0] coord_b;
    logic [CoordW-1:0] coord_c;
    logic [CoordW-1:0] coord_d;
    logic              write_sign;
    logic [MagW-1:0]   write_magnitude;
    logic signed [GaussW-1:0] gauss_sample;
    logic [NluW-1:0]   neg_log_uniform;
  } req_t;

  typedef struct packed {
    logic            site_sign;
    logic [MagW-1:0] site_magnitude;
    logic            accepted;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OWN, ST_OWN_WAIT, ST_NBR, ST_NBR_LAST, ST_SCALE, ST_PROP,
    ST_SQ, ST_QU, ST_TEST, ST_COMMIT, ST_WRITE, ST_READ_WAIT, ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       latch;      // capture request
    logic       rd_own;     // read addressed site
    logic       rd_nbr;     // read neighbour nbr_idx
    logic [NbrCntW-1:0] nbr_idx;
    logic       cap_own;    // capture own read data
    logic       acc_nbr;    // accumulate neighbour read data
    logic       scale;
    logic       prop;
    logic       square;
    logic       quart;
    logic       test;
    logic       commit;
    logic       wr_req;
    logic       cap_read;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [NbrCntW-1:0] nbr_count;
  } sts_t;
endpackage
`default_nettype wire

### sv/lmsu_if.sv
// Valid/ready channel interface.
`default_nettype none
interface lmsu_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/lmsu_ctrl.sv
// Controller state machine for the site update unit.
`default_nettype none
module lmsu_ctrl import lmsu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic out_busy_i,
  output cmd_t      cmd_o,
  input  wire sts_t sts_i
);
  state_e state_q, state_d;
  logic [NbrCntW-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_OWN;
      ST_OWN: begin
        unique case (sts_i.op)
          OP_WRITE:  state_d = ST_WRITE;
          OP_UPDATE: state_d = ST_OWN_WAIT;
          default:   state_d = ST_READ_WAIT;
        endcase
      end
      ST_OWN_WAIT: begin
        state_d = ST_NBR;
        idx_d   = '0;
      end
      ST_NBR: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == sts_i.nbr_count - 1'b1) state_d = ST_NBR_LAST;
      end
      ST_NBR_LAST: state_d = ST_SCALE;
      ST_SCALE:    state_d = ST_PROP;
      ST_PROP:     state_d = ST_SQ;
      ST_SQ:       state_d = ST_QU;
      ST_QU:       state_d = ST_TEST;
      ST_TEST:     state_d = ST_COMMIT;
      ST_COMMIT:   state_d = ST_OUT;
      ST_WRITE:    state_d = ST_OUT;
      ST_READ_WAIT: state_d = ST_OUT;
      ST_OUT:      if (!out_busy_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.nbr_idx = idx_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
      end
      ST_OWN: begin
        cmd_o.rd_own = 1'b1;
        cmd_o.wr_req = (sts_i.op == OP_WRITE);
      end
      ST_OWN_WAIT: cmd_o.cap_own = 1'b1;
      ST_NBR: begin
        cmd_o.rd_nbr  = 1'b1;
        cmd_o.acc_nbr = (idx_q != '0);
      end
      ST_NBR_LAST: cmd_o.acc_nbr = 1'b1;
      ST_SCALE:    cmd_o.scale = 1'b1;
      ST_PROP:     cmd_o.prop = 1'b1;
      ST_SQ:       cmd_o.square = 1'b1;
      ST_QU:       cmd_o.quart = 1'b1;
      ST_TEST:     cmd_o.test = 1'b1;
      ST_COMMIT:   cmd_o.commit = 1'b1;
      ST_WRITE:    cmd_o.load_out = 1'b1;
      ST_READ_WAIT: cmd_o.cap_read = 1'b1;
      ST_OUT:      ;
      default:     ;
    endcase
  end
endmodule
`default_nettype wire

### sv/lmsu_datapath.sv
// Datapath: lattice store, neighbour accumulation and acceptance test.
`default_nettype none
module lmsu_datapath import lmsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic [2:0] dims_i,
  input  wire logic [4:0] side_i,
  input  wire logic [15:0] kappa_i,
  input  wire logic [15:0] coup_i,
  input  wire req_t       req_i,
  input  wire cmd_t       cmd_i,
  output sts_t            sts_o,
  output rsp_t            rsp_o
);
  logic [MagW:0] mem_q [Depth];
  logic [MagW:0] rd_q;

  req_t req_q;
  logic [CoordW-1:0] c_q [MaxDims];
  logic [2:0] dims_q;
  logic [4:0] side_q;
  logic [AddrW-1:0] base;
  logic own_sign_q;
  logic [MagW-1:0] own_mag_q;
  logic signed [SumW-1:0] sum_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [PropW-1:0] v_q;
  logic [MagW-1:0] mag_sat;
  logic [SqW-1:0] sq_new_q, sq_old_q;
  logic [QuW-1:0] qu_new_q, qu_old_q;
  logic acc_q;
  rsp_t rsp_q;

  logic [CoordW:0] cin [MaxDims];
  logic [CoordW-1:0] cmod [MaxDims];
  logic [2:0] dims_eff;
  logic [4:0] side_eff;

  always_comb begin
    dims_eff = dims_i;
    if (dims_i < 3'd2) dims_eff = 3'd2;
    if (dims_i > 3'(MaxDims)) dims_eff = 3'(MaxDims);
    side_eff = side_i;
    if (side_i < 5'd2) side_eff = 5'd2;
    if (side_i > 5'(SideMax)) side_eff = 5'(SideMax);
    cin[0] = {1'b0, req_i.coord_a};
    cin[1] = {1'b0, req_i.coord_b};
    cin[2] = {1'b0, req_i.coord_c};
    cin[3] = {1'b0, req_i.coord_d};
  end

  // coordinate mod side: remainder of a 4-bit value by up to 16 (<= 8 steps)
  for (genvar g = 0; g < MaxDims; g++) begin : g_mod
    always_comb begin
      logic [CoordW:0] r;
      r = cin[g];
      for (int k = 0; k < 8; k++)
        if (r >= side_eff) r = r - side_eff;
      cmod[g] = r[CoordW-1:0];
    end
  end

  // addressed site; unused coordinates are already zero
  assign base = {c_q[0], c_q[1], c_q[2], c_q[3]};

  // neighbour address
  logic [AddrW-1:0] nbr_addr;
  always_comb begin
    logic [CoordW-1:0] n [MaxDims];
    logic [$clog2(MaxDims)-1:0] ax;
    logic [CoordW:0] t;
    for (int i = 0; i < MaxDims; i++) n[i] = c_q[i];
    ax = cmd_i.nbr_idx[$clog2(MaxDims):1];
    t = {1'b0, c_q[ax]};
    if (cmd_i.nbr_idx[0]) begin
      t = t + 1'b1;
      if (t >= side_q) t = '0;
    end else begin
      if (t == '0) t = side_q - 1'b1;
      else t = t - 1'b1;
    end
    n[ax] = t[CoordW-1:0];
    for (int i = 0; i < MaxDims; i++)
      if (i >= dims_q) n[i] = '0;
    nbr_addr = {n[0], n[1], n[2], n[3]};
  end

  logic [AddrW-1:0] rd_addr;
  assign rd_addr = cmd_i.rd_nbr ? nbr_addr : base;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_req)
      mem_q[base] <= {req_q.write_sign, req_q.write_magnitude};
    else if (cmd_i.commit && acc_q)
      mem_q[base] <= {own_sign_q ^ ~(v_q > 0), mag_sat};
    if (cmd_i.rd_own || cmd_i.rd_nbr) rd_q <= mem_q[rd_addr];
  end

  logic signed [ProdW-1:0] prod_r;
  logic signed [LhsW-1:0] lhs, rhs;
  always_comb begin
    prod_r = prod_q + ProdW'(32768);
    lhs = LhsW'($signed({1'b0, qu_new_q}) - $signed({1'b0, qu_old_q}))
          * $signed({1'b0, coup_i});
    rhs = $signed(LhsW'(req_q.neg_log_uniform) << 16);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= req_i;
      dims_q <= dims_eff;
      side_q <= side_eff;
      for (int i = 0; i < MaxDims; i++)
        c_q[i] <= (i < dims_eff) ? cmod[i] : '0;
    end
    if (cmd_i.cap_own) begin
      own_sign_q <= rd_q[MagW];
      own_mag_q  <= rd_q[MagW-1:0];
      sum_q      <= '0;
    end
    if (cmd_i.acc_nbr) begin
      if (rd_q[MagW] == own_sign_q) sum_q <= sum_q + SumW'(rd_q[MagW-1:0]);
      else sum_q <= sum_q - SumW'(rd_q[MagW-1:0]);
    end
    if (cmd_i.scale) prod_q <= ProdW'(sum_q) * $signed({1'b0, kappa_i});
    if (cmd_i.prop)
      v_q <= PropW'(prod_r >>> 16) + PropW'($signed(req_q.gauss_sample));
    if (cmd_i.square) begin
      sq_new_q <= SqW'(((2*MagW)'(mag_sat) * mag_sat + (2*MagW)'(32768)) >> 16);
      sq_old_q <= SqW'(((2*MagW)'(own_mag_q) * own_mag_q + (2*MagW)'(32768)) >> 16);
    end
    if (cmd_i.quart) begin
      qu_new_q <= QuW'(((2*SqW)'(sq_new_q) * sq_new_q + (2*SqW)'(32768)) >> 16);
      qu_old_q <= QuW'(((2*SqW)'(sq_old_q) * sq_old_q + (2*SqW)'(32768)) >> 16);
    end
    if (cmd_i.test) acc_q <= lhs < rhs;
    if (cmd_i.commit) begin
      rsp_q.accepted <= acc_q;
      rsp_q.site_sign <= acc_q ? own_sign_q ^ ~(v_q > 0) : own_sign_q;
      rsp_q.site_magnitude <= acc_q ? mag_sat : own_mag_q;
    end
    if (cmd_i.load_out) begin
      rsp_q.accepted <= 1'b0;
      rsp_q.site_sign <= req_q.write_sign;
      rsp_q.site_magnitude <= req_q.write_magnitude;
    end
    if (cmd_i.cap_read) begin
      rsp_q.accepted <= 1'b0;
      rsp_q.site_sign <= rd_q[MagW];
      rsp_q.site_magnitude <= rd_q[MagW-1:0];
    end
  end

  // saturated |v| of the proposal
  logic [PropW-1:0] vabs;
  always_comb vabs = v_q[PropW-1] ? PropW'(-v_q) : PropW'(v_q);
  always_comb mag_sat = (vabs > PropW'(MagMax)) ? MagMax : vabs[MagW-1:0];

  assign sts_o.op = req_q.op;
  assign sts_o.nbr_count = NbrCntW'({dims_q, 1'b0});
  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

### sv/lattice_metropolis_site_update_unit.sv
// Top level of the lattice Metropolis site update unit.
// The unit takes one request at a time. An update makes one lattice memory
// read per neighbour, then runs the kappa multiply, proposal, square, fourth
// power and coupling compare steps.
// The result stays in an output register until taken. Configuration writes
// are taken at any cycle and must only be made while the unit is idle.
`default_nettype none
module lattice_metropolis_site_update_unit import lmsu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  lmsu_if.sink   in_ch,
  lmsu_if.source out_ch
);
  logic [2:0]  dims_q;
  logic [4:0]  side_q;
  logic [15:0] kappa_q, coup_q;
  logic        out_valid_q;
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;
  logic in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= 3'd2;
      side_q  <= 5'd16;
      kappa_q <= 16'd6554;
      coup_q  <= 16'd655;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_DIMS:  dims_q  <= cfg_data_i[2:0];
        CFG_SIDE:  side_q  <= cfg_data_i[4:0];
        CFG_KAPPA: kappa_q <= cfg_data_i;
        CFG_COUP:  coup_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lmsu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .out_busy_i (out_valid_q && !out_ch.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lmsu_datapath u_dp (
    .clk_i,
    .dims_i  (dims_q),
    .side_i  (side_q),
    .kappa_i (kappa_q),
    .coup_i  (coup_q),
    .req_i   (in_ch.data),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .rsp_o   (rsp)
  );

  // result register valid: set when a result is loaded, cleared when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.commit || cmd.load_out || cmd.cap_read) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
    end
  end

  assign in_ch.ready  = in_ready && !out_valid_q;
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = rsp;

`ifndef SYNTHESIS
  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> !in_ch.ready) else $error("input taken with result pending");
  a_result_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit || cmd.load_out || cmd.cap_read) |=> out_ch.valid)
    else $error("loaded result not presented");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("pending result changed");
`endif
endmodule
`default_nettype wire
